[hw/rtl/rhm_pkg.sv]
// rhm_pkg: shared types and constants for the radius hit merger.
// No dependencies.
`timescale 1ns / 1ps
package rhm_pkg;
    typedef struct packed {
        logic               opcode;
        logic [23:0]        energy_deposit;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  hit_index;
        logic [31:0] hit_energy;
    } t_out;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_MERGED  = 3'd1;
    localparam logic [2:0] ST_NEW     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [15:0] RES_RESET = 16'd50;
endpackage

[hw/rtl/rhm_fifo.sv]
// rhm_fifo: small two-entry queue used between front and back, and on the output.
// Depends on nothing; width is a parameter.
`timescale 1ns / 1ps
module rhm_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("fifo count overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_push) |=> r_cnt == 2'd0) else $error("fifo count grew");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("fifo pointers disagree");
endmodule

[hw/rtl/rhm_engine.sv]
// rhm_engine: back end; scans the hit table one entry at a time (read, difference, square, compare) and updates it.
// Depends on rhm_pkg.
`timescale 1ns / 1ps
module rhm_engine #(
    parameter int MAX_HITS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_res,
    input  logic           i_empty,
    input  rhm_pkg::t_in   i_item,
    output logic           o_pop,
    input  logic           i_out_full,
    output logic           o_push,
    output rhm_pkg::t_out  o_res
);
    import rhm_pkg::*;

    localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW = $clog2(MAX_HITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_DIFF  = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [15:0] r_mx [MAX_HITS];
    logic [15:0] r_my [MAX_HITS];
    logic [15:0] r_mz [MAX_HITS];
    logic [31:0] r_ms [MAX_HITS];

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [15:0]   r_hx, r_hy, r_hz;
    logic [31:0]   r_hs;
    logic [16:0]   r_dx, r_dy, r_dz;
    logic [33:0]   r_sx, r_sy, r_sz;
    logic [31:0]   r_lim;
    t_out          r_out;
    logic          r_wr;
    logic [IW-1:0] r_waddr;
    logic [31:0]   r_wsum;
    logic          r_wpos;

    logic signed [16:0] w_ax, w_ay, w_az;
    logic [35:0]        w_d2;
    logic [32:0]        w_sum;
    logic [IW-1:0]      w_ridx;
    logic [5:0]         w_oidx;

    assign w_ridx = r_idx[IW-1:0];
    assign w_ax = {r_hx[15], r_hx} - {i_item.pos_x[15], i_item.pos_x};
    assign w_ay = {r_hy[15], r_hy} - {i_item.pos_y[15], i_item.pos_y};
    assign w_az = {r_hz[15], r_hz} - {i_item.pos_z[15], i_item.pos_z};
    assign w_d2 = {2'b0, r_sx} + {2'b0, r_sy} + {2'b0, r_sz};
    assign w_sum = {1'b0, r_hs} + {9'b0, i_item.energy_deposit};
    assign w_oidx = 6'(r_idx);

    assign o_pop  = (r_state == S_OUT) && !i_out_full;
    assign o_push = (r_state == S_OUT);
    assign o_res  = r_out;

    // table memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_ms[r_waddr] <= r_wsum;
            if (r_wpos) begin
                r_mx[r_waddr] <= i_item.pos_x;
                r_my[r_waddr] <= i_item.pos_y;
                r_mz[r_waddr] <= i_item.pos_z;
            end
        end
        r_hx <= r_mx[w_ridx];
        r_hy <= r_my[w_ridx];
        r_hz <= r_mz[w_ridx];
        r_hs <= r_ms[w_ridx];
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= w_ax[16] ? 17'(-w_ax) : 17'(w_ax);
        r_dy  <= w_ay[16] ? 17'(-w_ay) : 17'(w_ay);
        r_dz  <= w_az[16] ? 17'(-w_az) : 17'(w_az);
        r_sx  <= r_dx * r_dx;
        r_sy  <= r_dy * r_dy;
        r_sz  <= r_dz * r_dz;
        r_lim <= i_res * i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_wr    <= 1'b0;
        end else begin
            r_wr <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (!i_empty) begin
                        if (i_item.opcode == OP_CLEAR) begin
                            r_count <= '0;
                            r_out   <= '{ST_CLEARED, 6'd0, 32'd0};
                            r_state <= S_OUT;
                        end else if (i_item.energy_deposit == 24'd0) begin
                            r_out   <= '{ST_IGNORED, 6'd0, 32'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx == r_count) begin
                        if (r_count == CW'(MAX_HITS)) begin
                            r_out <= '{ST_FULL, 6'd0, 32'd0};
                        end else begin
                            r_out   <= '{ST_NEW, w_oidx, {8'd0, i_item.energy_deposit}};
                            r_wr    <= 1'b1;
                            r_wpos  <= 1'b1;
                            r_waddr <= w_ridx;
                            r_wsum  <= {8'd0, i_item.energy_deposit};
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: r_state <= S_SQ;
                S_SQ:   r_state <= S_CMP;
                S_CMP: begin
                    if (w_d2 <= {4'd0, r_lim}) begin
                        r_out   <= '{ST_MERGED, w_oidx,
                                     w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0]};
                        r_wr    <= 1'b1;
                        r_wpos  <= 1'b0;
                        r_waddr <= w_ridx;
                        r_wsum  <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (!i_out_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_HITS)) else $error("hit count beyond table");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx < r_count)) else $error("scan past count");
    a_pop_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> o_push) else $error("item retired without result");
endmodule

[hw/rtl/radius_hit_merger.sv]
// radius_hit_merger: top level; input queue, table engine, result queue, config register.
// Depends on rhm_pkg, rhm_fifo, rhm_engine.
`timescale 1ns / 1ps
// Merges energy deposits into a hit table. Clear and zero-energy items go straight
// to the result; a deposit scans stored hits one at a time (read, difference, square,
// compare) until one lies within the resolution radius or the stored hits run out,
// up to MAX_HITS hits. The table has one read and one write port. Results wait in a
// two-beat queue, so the engine keeps going while the consumer stalls until that
// queue fills. Write the resolution only while idle.
module radius_hit_merger #(
    parameter int MAX_HITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  rhm_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output rhm_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);
    import rhm_pkg::*;

    logic [15:0] r_res;
    logic        w_q_empty, w_q_pop, w_o_full, w_o_push;
    t_in         w_item;
    t_out        w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= RES_RESET;
        end else if (i_cfg_valid) begin
            r_res <= i_cfg_data;
        end
    end

    rhm_fifo #(.W($bits(t_in))) u_in_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_data), .o_full(full),
        .i_pop(w_q_pop), .o_empty(w_q_empty), .o_data(w_item)
    );

    rhm_engine #(.MAX_HITS(MAX_HITS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_res(r_res),
        .i_empty(w_q_empty), .i_item(w_item), .o_pop(w_q_pop),
        .i_out_full(w_o_full), .o_push(w_o_push), .o_res(w_res)
    );

    rhm_fifo #(.W($bits(t_out))) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_o_push && !w_o_full), .i_data(w_res), .o_full(w_o_full),
        .i_pop(pop), .o_empty(empty), .o_data(o_data)
    );
endmodule
